// ===== hw/rtl/kwsm_pkg.sv =====
// Shared types and codes for the k-way sorted merge block.
package kwsm_pkg;

   typedef enum logic {
      CMD_APPEND = 1'b0,
      CMD_POP    = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      cmd_type            cmd;
      logic [2:0]         list_id;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic               out_valid;
      logic signed [31:0] out_value;
      logic [2:0]         source_list;
   } rsp_type;

endpackage

// ===== hw/rtl/kwsm_ram.sv =====
// Generic simple dual-port RAM with registered read.
module kwsm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/k_way_sorted_merge.sv =====
// Top level of the k-way sorted merge block: list FIFOs, head registers, min tree.
//
//   channel | direction | payload  | transfer when
//   req     | in        | req_type | req_valid && req_ready
//   rsp     | out       | rsp_type | rsp_valid && rsp_ready
//
// One item per cycle while no result is stalled: a transfer on req lands in the
// input register, and its result is then written into the result register.
// The throughput is set by the head registers and the min tree over them; the
// list RAM only refills the second head of a popped list.
// Reset clears fill counts and pointers at once; there is no clearing pass.
// A stalled result holds the result register; req_ready drops only while both
// the input and the result registers are full.
module k_way_sorted_merge
   import kwsm_pkg::*;
#(
   parameter int NUM_LISTS  = 8,
   parameter int LIST_DEPTH = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int ID_W      = $clog2(NUM_LISTS);
   localparam int PTR_W     = $clog2(LIST_DEPTH);
   localparam int CNT_W     = $clog2(LIST_DEPTH + 1);
   localparam int LEAVES    = 1 << ID_W;
   localparam int NODES     = 2 * LEAVES - 1;
   localparam int MEM_DEPTH = NUM_LISTS * (1 << PTR_W);
   localparam int ADDR_W    = $clog2(MEM_DEPTH);

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(LIST_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   logic                         in_vld_ff, in_vld_in;
   req_type                      in_ff, in_in;
   logic                         rsp_vld_ff, rsp_vld_in;
   rsp_type                      rsp_ff, rsp_in;
   logic [CNT_W-1:0]             cnt_ff [NUM_LISTS];
   logic [CNT_W-1:0]             cnt_in [NUM_LISTS];
   logic [PTR_W-1:0]             hp_ff  [NUM_LISTS];
   logic [PTR_W-1:0]             hp_in  [NUM_LISTS];
   logic [PTR_W-1:0]             tp_ff  [NUM_LISTS];
   logic [PTR_W-1:0]             tp_in  [NUM_LISTS];
   logic signed [DATA_WIDTH-1:0] head0_ff [NUM_LISTS];
   logic signed [DATA_WIDTH-1:0] head0_in [NUM_LISTS];
   logic signed [DATA_WIDTH-1:0] head1_ff [NUM_LISTS];
   logic signed [DATA_WIDTH-1:0] head1_in [NUM_LISTS];
   logic                         pend_ff, pend_in;
   logic [ID_W-1:0]              pend_id_ff, pend_id_in;

   logic                         advance;
   logic                         node_vld [NODES];
   logic signed [DATA_WIDTH-1:0] node_val [NODES];
   logic [ID_W-1:0]              node_idx [NODES];

   logic                         wr_en;
   logic [ADDR_W-1:0]            wr_addr;
   logic [DATA_WIDTH-1:0]        wr_data;
   logic                         rd_en;
   logic [ADDR_W-1:0]            rd_addr;
   logic [DATA_WIDTH-1:0]        rd_data;

   kwsm_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MEM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      in_vld_in = in_vld_ff;
      in_in     = in_ff;
      if (req_ready) begin
         in_vld_in = req_valid;
         if (req_valid) begin
            in_in = req_data;
         end
      end
   end

   // min tree, right operand wins ties
   always_comb begin
      logic take_right;
      for (int j = 0; j < LEAVES; j++) begin
         if (j < NUM_LISTS) begin
            node_vld[LEAVES-1+j] = (cnt_ff[j] != '0);
            node_val[LEAVES-1+j] = head0_ff[j];
         end else begin
            node_vld[LEAVES-1+j] = 1'b0;
            node_val[LEAVES-1+j] = '0;
         end
         node_idx[LEAVES-1+j] = ID_W'(j);
      end
      for (int n = LEAVES - 2; n >= 0; n--) begin
         take_right = node_vld[2*n+2] &&
                      (!node_vld[2*n+1] || (node_val[2*n+2] <= node_val[2*n+1]));
         node_vld[n] = node_vld[2*n+1] || node_vld[2*n+2];
         node_val[n] = take_right ? node_val[2*n+2] : node_val[2*n+1];
         node_idx[n] = take_right ? node_idx[2*n+2] : node_idx[2*n+1];
      end
   end

   always_comb begin
      logic [ID_W-1:0]              aid;
      logic [ID_W-1:0]              bid;
      logic                         id_ok;
      logic signed [DATA_WIDTH-1:0] aval;
      cnt_in     = cnt_ff;
      hp_in      = hp_ff;
      tp_in      = tp_ff;
      head0_in   = head0_ff;
      head1_in   = head1_ff;
      pend_in    = 1'b0;
      pend_id_in = pend_id_ff;
      wr_en      = 1'b0;
      wr_addr    = '0;
      wr_data    = '0;
      rd_en      = 1'b0;
      rd_addr    = '0;
      rsp_vld_in = rsp_vld_ff && !rsp_ready;
      rsp_in     = rsp_ff;
      aid        = ID_W'(in_ff.list_id);
      bid        = node_idx[0];
      id_ok      = 32'(in_ff.list_id) < NUM_LISTS;
      aval       = DATA_WIDTH'(in_ff.value);

      if (pend_ff) begin
         head1_in[pend_id_ff] = rd_data;
      end

      if (advance) begin
         rsp_vld_in         = 1'b1;
         rsp_in.status      = STATUS_OK;
         rsp_in.out_valid   = 1'b0;
         rsp_in.out_value   = '0;
         rsp_in.source_list = '0;
         case (in_ff.cmd)
            CMD_APPEND: begin
               if (!id_ok || cnt_ff[aid] == CNT_W'(LIST_DEPTH)) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = {aid, tp_ff[aid]};
                  wr_data = aval;
                  if (cnt_ff[aid] == CNT_W'(0)) begin
                     head0_in[aid] = aval;
                  end
                  if (cnt_ff[aid] == CNT_W'(1)) begin
                     head1_in[aid] = aval;
                  end
                  tp_in[aid]  = ptr_next(tp_ff[aid]);
                  cnt_in[aid] = cnt_ff[aid] + 1'b1;
               end
            end
            CMD_POP: begin
               if (!node_vld[0]) begin
                  rsp_in.status = STATUS_EMPTY;
               end else begin
                  rsp_in.out_valid   = 1'b1;
                  rsp_in.out_value   = 32'(node_val[0]);
                  rsp_in.source_list = 3'(bid);
                  head0_in[bid]      = head1_in[bid];
                  hp_in[bid]         = ptr_next(hp_ff[bid]);
                  cnt_in[bid]        = cnt_ff[bid] - 1'b1;
                  if (cnt_ff[bid] > CNT_W'(2)) begin
                     rd_en      = 1'b1;
                     rd_addr    = {bid, ptr_next(ptr_next(hp_ff[bid]))};
                     pend_in    = 1'b1;
                     pend_id_in = bid;
                  end
               end
            end
            default: begin
               rsp_in.status = STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         pend_ff    <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            cnt_ff[i] <= '0;
            hp_ff[i]  <= '0;
            tp_ff[i]  <= '0;
         end
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         pend_ff    <= pend_in;
         cnt_ff     <= cnt_in;
         hp_ff      <= hp_in;
         tp_ff      <= tp_in;
      end
      in_ff      <= in_in;
      rsp_ff     <= rsp_in;
      pend_id_ff <= pend_id_in;
      head0_ff   <= head0_in;
      head1_ff   <= head1_in;
   end

endmodule

// ===== hw/rtl/kwsm_checker.sv =====
// Port-level checks for the k-way sorted merge block, bound to its top level.
module kwsm_checker
   import kwsm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   assert property (@(posedge clock) reset |=> !rsp_valid && req_ready)
      else $error("result or stall present right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transfer changed or dropped");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_valid |-> rsp_data.status == STATUS_OK)
      else $error("popped element reported with a failure status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.out_valid |->
         rsp_data.out_value == 32'd0 && rsp_data.source_list == 3'd0)
      else $error("result without element carries nonzero fields");

endmodule

bind k_way_sorted_merge kwsm_checker u_checker (.*);
